// File: design/hlfa_pkg.sv
// Shared types, constants and sequencer states of the hole list allocator.
package hlfa_pkg;

    localparam int HOLES_MAX = 256;
    localparam int IDX_W     = $clog2(HOLES_MAX);
    localparam int CNT_W     = $clog2(HOLES_MAX + 1);

    localparam int SIZE_W    = 16;
    localparam int OFF_W     = 32;
    localparam int COUNT_W   = 9;
    localparam int SPACE_W   = 24;
    localparam int MODE_W    = 2;
    localparam int ENTRY_W   = SIZE_W + OFF_W;

    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FROM_HOLE = 3'd0,
        ST_FROM_END  = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_LIST_FULL = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SIZE_W-1:0] block_size;
        logic [OFF_W-1:0]  block_offset;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   offset;
        logic [COUNT_W-1:0] hole_count;
        logic [SPACE_W-1:0] hole_space;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } entry_t;

    // request to the list engine
    typedef struct packed {
        logic              valid;
        logic              insert;
        logic              sorted;
        logic              ascending;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } eng_req_t;

    // completion from the list engine
    typedef struct packed {
        logic             done;
        logic             found;
        logic [OFF_W-1:0] hole_offset;
        logic [CNT_W-1:0] count;
    } eng_rsp_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_FSCAN,
        E_DSHIFT,
        E_ISETUP,
        E_ISCAN,
        E_ISHIFT,
        E_IWRITE,
        E_DONE
    } eng_state_t;

endpackage

// File: design/hlfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module hlfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/hlfa_engine.sv
// Hole list engine: sequencer that scans, deletes and inserts list entries one per cycle.
module hlfa_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  hlfa_pkg::eng_req_t req,
    output hlfa_pkg::eng_rsp_t rsp
);

    hlfa_pkg::eng_state_t state_reg, state_next;

    logic [hlfa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [hlfa_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [hlfa_pkg::IDX_W-1:0]  pos_reg, pos_next;
    logic [hlfa_pkg::SIZE_W-1:0] req_size_reg, req_size_next;
    logic [hlfa_pkg::SIZE_W-1:0] ins_size_reg, ins_size_next;
    logic [hlfa_pkg::OFF_W-1:0]  ins_off_reg, ins_off_next;
    logic [hlfa_pkg::OFF_W-1:0]  hole_off_reg, hole_off_next;
    logic                        sorted_reg, sorted_next;
    logic                        asc_reg, asc_next;
    logic                        found_reg, found_next;

    logic                        ram_we;
    logic [hlfa_pkg::IDX_W-1:0]  ram_waddr;
    logic [hlfa_pkg::IDX_W-1:0]  ram_raddr;
    hlfa_pkg::entry_t            ram_wdata;
    hlfa_pkg::entry_t            ram_rdata;

    logic                        idx_is_last;
    logic                        del_last;
    logic                        fit_hit;
    logic                        ins_after;

    hlfa_ram #(
        .WIDTH(hlfa_pkg::ENTRY_W),
        .DEPTH(hlfa_pkg::HOLES_MAX)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // shared compare unit
    assign idx_is_last = (hlfa_pkg::CNT_W'(idx_reg) == (count_reg - hlfa_pkg::CNT_W'(1)));
    assign del_last    = ((hlfa_pkg::CNT_W'(idx_reg) + hlfa_pkg::CNT_W'(2)) == count_reg);
    assign fit_hit     = (ram_rdata.size >= req_size_reg);
    assign ins_after   = asc_reg ? (ram_rdata.size > ins_size_reg)
                                 : (ram_rdata.size < ins_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hlfa_pkg::E_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        req_size_reg <= req_size_next;
        ins_size_reg <= ins_size_next;
        ins_off_reg  <= ins_off_next;
        hole_off_reg <= hole_off_next;
        sorted_reg   <= sorted_next;
        asc_reg      <= asc_next;
        found_reg    <= found_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hlfa_pkg::E_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.insert)
                        state_next = hlfa_pkg::E_ISETUP;
                    else if (count_reg == '0)
                        state_next = hlfa_pkg::E_DONE;
                    else
                        state_next = hlfa_pkg::E_FSCAN;
                end
            end
            hlfa_pkg::E_FSCAN:
            begin
                if (fit_hit)
                begin
                    if (!idx_is_last)
                        state_next = hlfa_pkg::E_DSHIFT;
                    else if (ram_rdata.size != req_size_reg)
                        state_next = hlfa_pkg::E_ISETUP;
                    else
                        state_next = hlfa_pkg::E_DONE;
                end
                else if (idx_is_last)
                begin
                    state_next = hlfa_pkg::E_DONE;
                end
            end
            hlfa_pkg::E_DSHIFT:
            begin
                if (del_last)
                    state_next = (ins_size_reg != '0) ? hlfa_pkg::E_ISETUP : hlfa_pkg::E_DONE;
            end
            hlfa_pkg::E_ISETUP:
            begin
                if (!sorted_reg || count_reg == '0)
                    state_next = hlfa_pkg::E_IWRITE;
                else
                    state_next = hlfa_pkg::E_ISCAN;
            end
            hlfa_pkg::E_ISCAN:
            begin
                if (ins_after)
                    state_next = hlfa_pkg::E_ISHIFT;
                else if (idx_is_last)
                    state_next = hlfa_pkg::E_IWRITE;
            end
            hlfa_pkg::E_ISHIFT:
            begin
                if (idx_reg == pos_reg)
                    state_next = hlfa_pkg::E_IWRITE;
            end
            hlfa_pkg::E_IWRITE:
            begin
                state_next = hlfa_pkg::E_DONE;
            end
            hlfa_pkg::E_DONE:
            begin
                state_next = hlfa_pkg::E_IDLE;
            end
            default:
            begin
                state_next = hlfa_pkg::E_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        req_size_next   = req_size_reg;
        ins_size_next   = ins_size_reg;
        ins_off_next    = ins_off_reg;
        hole_off_next   = hole_off_reg;
        sorted_next     = sorted_reg;
        asc_next        = asc_reg;
        found_next      = found_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg;
        rsp.done        = 1'b0;
        rsp.found       = found_reg;
        rsp.hole_offset = hole_off_reg;
        rsp.count       = count_reg;

        unique case (state_reg)
            hlfa_pkg::E_IDLE:
            begin
                if (req.valid)
                begin
                    req_size_next = req.size;
                    ins_size_next = req.size;
                    ins_off_next  = req.offset;
                    sorted_next   = req.sorted;
                    asc_next      = req.ascending;
                    found_next    = 1'b0;
                    idx_next      = '0;
                    ram_raddr     = '0;
                end
            end
            hlfa_pkg::E_FSCAN:
            begin
                // data for entry idx is on the RAM output
                ram_raddr = idx_reg + hlfa_pkg::IDX_W'(1);
                if (fit_hit)
                begin
                    found_next    = 1'b1;
                    hole_off_next = ram_rdata.offset;
                    ins_size_next = ram_rdata.size - req_size_reg;
                    ins_off_next  = ram_rdata.offset + hlfa_pkg::OFF_W'(req_size_reg);
                    if (idx_is_last)
                        count_next = count_reg - hlfa_pkg::CNT_W'(1);
                end
                else
                begin
                    idx_next = idx_reg + hlfa_pkg::IDX_W'(1);
                end
            end
            hlfa_pkg::E_DSHIFT:
            begin
                // entry idx+1 moves down to idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_raddr = idx_reg + hlfa_pkg::IDX_W'(2);
                idx_next  = idx_reg + hlfa_pkg::IDX_W'(1);
                if (del_last)
                    count_next = count_reg - hlfa_pkg::CNT_W'(1);
            end
            hlfa_pkg::E_ISETUP:
            begin
                idx_next  = '0;
                ram_raddr = '0;
                pos_next  = count_reg[hlfa_pkg::IDX_W-1:0];
            end
            hlfa_pkg::E_ISCAN:
            begin
                if (ins_after)
                begin
                    pos_next  = idx_reg;
                    idx_next  = hlfa_pkg::IDX_W'(count_reg - hlfa_pkg::CNT_W'(1));
                    ram_raddr = hlfa_pkg::IDX_W'(count_reg - hlfa_pkg::CNT_W'(1));
                end
                else
                begin
                    idx_next  = idx_reg + hlfa_pkg::IDX_W'(1);
                    ram_raddr = idx_reg + hlfa_pkg::IDX_W'(1);
                end
            end
            hlfa_pkg::E_ISHIFT:
            begin
                // entry idx moves up to idx+1, from the tail down to pos
                ram_we    = 1'b1;
                ram_waddr = idx_reg + hlfa_pkg::IDX_W'(1);
                idx_next  = idx_reg - hlfa_pkg::IDX_W'(1);
                ram_raddr = idx_reg - hlfa_pkg::IDX_W'(1);
            end
            hlfa_pkg::E_IWRITE:
            begin
                ram_we           = 1'b1;
                ram_waddr        = pos_reg;
                ram_wdata.size   = ins_size_reg;
                ram_wdata.offset = ins_off_reg;
                count_next       = count_reg + hlfa_pkg::CNT_W'(1);
            end
            hlfa_pkg::E_DONE:
            begin
                rsp.done = 1'b1;
            end
            default:
            begin
                rsp.done = 1'b0;
            end
        endcase
    end

endmodule

// File: design/hole_list_fit_allocator_top.sv
// Top level of the hole list allocator: command port, bookkeeping and result register.
//
// Allocates and releases blocks of a byte store from a list of up to HOLES_MAX free
// holes (256), kept in insertion order (fit_mode 0, and 3), ascending size order
// (1, best fit) or descending size order (2, worst fit). An item is taken when start
// is high and busy is low. Every item gives exactly one result, shown on result for a
// single cycle with done high; the receiver cannot hold it off, so it must take it
// then. Zero-size items and releases into a full list touch no list entry: their
// result comes in the cycle after acceptance and busy stays low. All other items go to
// the list engine, which walks the hole RAM one entry per cycle through its single
// read port, and busy stays high until the result cycle. A release writes the hole
// at the tail in first fit and, in sorted modes, runs the insertion scan, then the
// shift up. An allocate takes the fit scan plus the shift down behind a hit entry
// and, for a larger hole, the remnant insertion. fit_mode is written through
// cfg_we / cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce it. A change of mode does not re-sort the list.
// The hole RAM is not cleared at reset: only entries below the hole count are
// ever used.
module hole_list_fit_allocator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hlfa_pkg::MODE_W-1:0]       cfg_data,
    input  logic                              start,
    input  hlfa_pkg::item_t                   item,
    output logic                              busy,
    output logic                              done,
    output hlfa_pkg::result_t                 result
);

    logic [hlfa_pkg::MODE_W-1:0]  fit_mode_reg;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    hlfa_pkg::result_t            result_reg, result_next;
    hlfa_pkg::item_t              item_reg, item_next;
    logic [hlfa_pkg::OFF_W-1:0]   store_end_reg, store_end_next;
    logic [hlfa_pkg::SPACE_W-1:0] free_total_reg, free_total_next;

    hlfa_pkg::eng_req_t           eng_req;
    hlfa_pkg::eng_rsp_t           eng_rsp;

    logic                         accept;
    logic                         mode_sorted;
    logic                         mode_asc;
    logic                         list_full;
    logic [hlfa_pkg::OFF_W:0]     end_sum;
    logic [hlfa_pkg::SPACE_W:0]   space_sum;
    logic [hlfa_pkg::COUNT_W-1:0] count_now;

    hlfa_engine u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (eng_req),
        .rsp  (eng_rsp)
    );

    assign accept    = start && !busy_reg;
    assign list_full = (eng_rsp.count == hlfa_pkg::CNT_W'(hlfa_pkg::HOLES_MAX));
    assign count_now = hlfa_pkg::COUNT_W'(eng_rsp.count);

    // mode 3 falls back to first fit
    always_comb
    begin
        unique case (fit_mode_reg)
            hlfa_pkg::MODE_BEST:
            begin
                mode_sorted = 1'b1;
                mode_asc    = 1'b1;
            end
            hlfa_pkg::MODE_WORST:
            begin
                mode_sorted = 1'b1;
                mode_asc    = 1'b0;
            end
            default:
            begin
                mode_sorted = 1'b0;
                mode_asc    = 1'b0;
            end
        endcase
    end

    // store end advance with carry out for the exhaustion check
    assign end_sum   = {1'b0, store_end_reg} + (hlfa_pkg::OFF_W + 1)'(item_reg.block_size);
    assign space_sum = {1'b0, free_total_reg} + (hlfa_pkg::SPACE_W + 1)'(item_reg.block_size);

    always_comb
    begin
        eng_req.valid     = 1'b0;
        eng_req.insert    = (item.cmd == hlfa_pkg::CMD_RELEASE);
        eng_req.sorted    = mode_sorted;
        eng_req.ascending = mode_asc;
        eng_req.size      = item.block_size;
        eng_req.offset    = item.block_offset;

        busy_next       = busy_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        item_next       = item_reg;
        store_end_next  = store_end_reg;
        free_total_next = free_total_reg;

        if (accept)
        begin
            item_next              = item;
            result_next.offset     = '0;
            result_next.hole_count = count_now;
            result_next.hole_space = free_total_reg;
            if (item.block_size == '0)
            begin
                // zero size: no list work
                done_next = 1'b1;
                if (item.cmd == hlfa_pkg::CMD_RELEASE)
                begin
                    result_next.status = hlfa_pkg::ST_RELEASED;
                end
                else
                begin
                    result_next.status = hlfa_pkg::ST_FROM_END;
                    result_next.offset = store_end_reg;
                end
            end
            else if (item.cmd == hlfa_pkg::CMD_RELEASE && list_full)
            begin
                done_next          = 1'b1;
                result_next.status = hlfa_pkg::ST_LIST_FULL;
            end
            else
            begin
                eng_req.valid = 1'b1;
                busy_next     = 1'b1;
            end
        end
        else if (eng_rsp.done)
        begin
            busy_next              = 1'b0;
            done_next              = 1'b1;
            result_next.offset     = '0;
            result_next.hole_count = count_now;
            if (item_reg.cmd == hlfa_pkg::CMD_RELEASE)
            begin
                // saturating space count
                free_total_next    = space_sum[hlfa_pkg::SPACE_W] ? '1
                                   : space_sum[hlfa_pkg::SPACE_W-1:0];
                result_next.status = hlfa_pkg::ST_RELEASED;
            end
            else if (eng_rsp.found)
            begin
                free_total_next    = (free_total_reg >= hlfa_pkg::SPACE_W'(item_reg.block_size))
                                   ? free_total_reg - hlfa_pkg::SPACE_W'(item_reg.block_size)
                                   : '0;
                result_next.status = hlfa_pkg::ST_FROM_HOLE;
                result_next.offset = eng_rsp.hole_offset;
            end
            else if (end_sum[hlfa_pkg::OFF_W])
            begin
                result_next.status = hlfa_pkg::ST_EXHAUSTED;
            end
            else
            begin
                store_end_next     = end_sum[hlfa_pkg::OFF_W-1:0];
                result_next.status = hlfa_pkg::ST_FROM_END;
                result_next.offset = store_end_reg;
            end
            result_next.hole_space = free_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= '0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            store_end_reg  <= '0;
            free_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fit_mode_reg <= cfg_data;
            end
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            store_end_reg  <= store_end_next;
            free_total_reg <= free_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        item_reg   <= item_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: design/hlfa_checker.sv
// Port-level checker for the hole list allocator, bound to the top level.
module hlfa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input hlfa_pkg::item_t             item,
    input logic                        busy,
    input logic                        done,
    input hlfa_pkg::result_t           result
);

    // zero-size allocate answers at once from the store end
    a_zero_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.cmd == hlfa_pkg::CMD_ALLOC && item.block_size == '0
        |=> done && result.status == hlfa_pkg::ST_FROM_END)
        else $error("zero-size allocate not answered next cycle");

    // engine work ends only with its result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // no result without an item behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy) || $past(busy))
        else $error("result without an item");

    // offset is zero on every result that allocates no block
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == hlfa_pkg::ST_RELEASED
                 || result.status == hlfa_pkg::ST_LIST_FULL
                 || result.status == hlfa_pkg::ST_EXHAUSTED)
        |-> result.offset == '0)
        else $error("non-zero offset on non-allocating result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.hole_count <= hlfa_pkg::COUNT_W'(hlfa_pkg::HOLES_MAX))
        else $error("hole count beyond list size");

endmodule

bind hole_list_fit_allocator_top hlfa_checker u_hlfa_checker (.*);
